FILE: hdl/dtve_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// dtve_pkg
// Shared types and constants for the tag value extractor: payload structs,
// status codes, scan phase encoding and sizing constants.
// ============================================================================
package dtve_pkg;

    localparam int MAX_VALUE_BYTES = 64;
    localparam int VLEN_W          = $clog2(MAX_VALUE_BYTES + 1);
    localparam int POS_W           = 17;
    localparam int HDR_CNT_W       = 3;

    localparam logic [15:0] RST_TAG_GROUP    = 16'd8;
    localparam logic [15:0] RST_TAG_ELEMENT  = 16'd8;
    localparam logic [15:0] RST_HEADER_LIMIT = 16'd10000;

    // length values above this use the upper half-word instead
    localparam logic [31:0] LEN_FALLBACK_MAX = 32'd256;

    localparam logic [1:0] CFG_TAG_GROUP    = 2'd0;
    localparam logic [1:0] CFG_TAG_ELEMENT  = 2'd1;
    localparam logic [1:0] CFG_HEADER_LIMIT = 2'd2;

    localparam logic [1:0] ST_VALUE     = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_TRUNC_HDR = 2'd3;

    typedef enum logic [3:0] {
        PH_SEARCH = 4'b0001,
        PH_LENGTH = 4'b0010,
        PH_VALUE  = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [7:0] value_byte;
        logic [1:0] status;
        logic       last;
    } out_item_t;

endpackage

FILE: hdl/dicom_tag_value_extractor_core.sv
`timescale 1ns / 1ps
// ============================================================================
// dicom_tag_value_extractor_core
// Scans a byte stream for a DICOM tag and returns the element value bytes.
// ============================================================================
// Usage:
//   in_*  : one file byte per request, end_of_stream on the final byte.
//   out_* : value bytes (status 0), or one status item (not found, empty,
//           truncated header); last marks the final item of each stream.
//   cfg_* : register writes (0 tag_group, 1 tag_element, 2 header_limit),
//           always ready, effective on the next byte. Index 3 is ignored.
// Timing:
//   One byte per cycle while no result is held or out_ready is high. The scan
//   state updates on the accepting edge and the result, if any, sits in the
//   output register on the next cycle. The output register is the only buffer,
//   so in_ready follows out_ready whenever a result is waiting.
// Reset:
//   Registers return to tag 0008,0008 and limit 10000; scan state clears.
//   Each end_of_stream also clears the scan state for the next file.
// Stall:
//   With out_ready low and a result held, no byte is accepted.
// ============================================================================
module dicom_tag_value_extractor_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  dtve_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output dtve_pkg::out_item_t  out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data
);

    localparam logic [dtve_pkg::POS_W-1:0] POS_MAX = '1;

    logic [15:0] tag_group_reg, tag_element_reg, header_limit_reg;

    dtve_pkg::phase_t                  phase_reg, phase_next;
    logic [31:0]                       window_reg, window_next;
    logic [dtve_pkg::POS_W-1:0]        pos_reg, pos_next;
    logic [dtve_pkg::HDR_CNT_W-1:0]    hdr_cnt_reg, hdr_cnt_next;
    logic [31:0]                       len_bytes_reg, len_bytes_next;
    logic [dtve_pkg::VLEN_W-1:0]       vlen_reg, vlen_next;
    logic [dtve_pkg::VLEN_W-1:0]       vcnt_reg, vcnt_next;

    logic                  out_valid_reg, out_valid_next;
    dtve_pkg::out_item_t   out_data_reg, out_data_next;

    logic                  in_fire;
    logic [31:0]           target;
    logic [31:0]           win_shift;
    logic                  tag_hit;
    logic [31:0]           len_merged;
    logic [31:0]           len_sel;
    logic [dtve_pkg::VLEN_W-1:0] len_clamped;
    logic [dtve_pkg::HDR_CNT_W-1:0] hdr_cnt_inc;
    logic [dtve_pkg::VLEN_W-1:0]    vcnt_inc;
    logic                  val_fin;
    logic                  emit;
    dtve_pkg::out_item_t   emit_item;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // tag bytes as they appear in the stream: group lo, group hi, elem lo, elem hi
    assign target    = {tag_group_reg[7:0], tag_group_reg[15:8],
                        tag_element_reg[7:0], tag_element_reg[15:8]};
    assign win_shift = {window_reg[23:0], in_data.data_byte};
    assign tag_hit   = (pos_reg >= dtve_pkg::POS_W'(3)) && (win_shift == target);

    assign len_merged  = len_bytes_reg
                       | ({24'd0, in_data.data_byte} << {hdr_cnt_reg[1:0], 3'b000});
    assign len_sel     = (len_merged > dtve_pkg::LEN_FALLBACK_MAX)
                       ? {16'd0, len_merged[31:16]} : len_merged;
    assign len_clamped = (len_sel > 32'(dtve_pkg::MAX_VALUE_BYTES))
                       ? dtve_pkg::VLEN_W'(dtve_pkg::MAX_VALUE_BYTES)
                       : len_sel[dtve_pkg::VLEN_W-1:0];
    assign hdr_cnt_inc = hdr_cnt_reg + 1'b1;
    assign vcnt_inc    = vcnt_reg + 1'b1;
    assign val_fin     = (vcnt_inc >= vlen_reg) || in_data.end_of_stream;

    always_comb
    begin
        phase_next     = phase_reg;
        window_next    = window_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        len_bytes_next = len_bytes_reg;
        vlen_next      = vlen_reg;
        vcnt_next      = vcnt_reg;
        emit           = 1'b0;
        emit_item      = '{value_byte: 8'd0, status: dtve_pkg::ST_VALUE, last: 1'b1};

        unique case (phase_reg)
            dtve_pkg::PH_SEARCH:
            begin
                window_next = win_shift;
                if (tag_hit)
                begin
                    if ((pos_reg - dtve_pkg::POS_W'(3))
                        >= {{(dtve_pkg::POS_W-16){1'b0}}, header_limit_reg})
                    begin
                        emit             = 1'b1;
                        emit_item.status = dtve_pkg::ST_NOT_FOUND;
                        phase_next       = dtve_pkg::PH_DONE;
                    end
                    else if (in_data.end_of_stream)
                    begin
                        emit             = 1'b1;
                        emit_item.status = dtve_pkg::ST_TRUNC_HDR;
                    end
                    else
                    begin
                        phase_next     = dtve_pkg::PH_LENGTH;
                        hdr_cnt_next   = '0;
                        len_bytes_next = '0;
                    end
                end
                else if (in_data.end_of_stream)
                begin
                    emit             = 1'b1;
                    emit_item.status = dtve_pkg::ST_NOT_FOUND;
                end
            end
            dtve_pkg::PH_LENGTH:
            begin
                len_bytes_next = len_merged;
                hdr_cnt_next   = hdr_cnt_inc;
                if (hdr_cnt_inc >= dtve_pkg::HDR_CNT_W'(4))
                begin
                    vlen_next = len_clamped;
                    vcnt_next = '0;
                    if (len_clamped == '0 || in_data.end_of_stream)
                    begin
                        emit             = 1'b1;
                        emit_item.status = dtve_pkg::ST_EMPTY;
                        phase_next       = dtve_pkg::PH_DONE;
                    end
                    else
                    begin
                        phase_next = dtve_pkg::PH_VALUE;
                    end
                end
                else if (in_data.end_of_stream)
                begin
                    emit             = 1'b1;
                    emit_item.status = dtve_pkg::ST_TRUNC_HDR;
                end
            end
            dtve_pkg::PH_VALUE:
            begin
                vcnt_next            = vcnt_inc;
                emit                 = 1'b1;
                emit_item.value_byte = in_data.data_byte;
                emit_item.status     = dtve_pkg::ST_VALUE;
                emit_item.last       = val_fin;
                if (val_fin)
                begin
                    phase_next = dtve_pkg::PH_DONE;
                end
            end
            dtve_pkg::PH_DONE:
            begin
                phase_next = dtve_pkg::PH_DONE;
            end
            default:
            begin
                phase_next = dtve_pkg::PH_SEARCH;
            end
        endcase

        pos_next = (pos_reg != POS_MAX) ? pos_reg + 1'b1 : pos_reg;

        if (in_data.end_of_stream)
        begin
            phase_next     = dtve_pkg::PH_SEARCH;
            window_next    = '0;
            pos_next       = '0;
            hdr_cnt_next   = '0;
            len_bytes_next = '0;
            vlen_next      = '0;
            vcnt_next      = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        if (in_fire && emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = emit_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_group_reg    <= dtve_pkg::RST_TAG_GROUP;
            tag_element_reg  <= dtve_pkg::RST_TAG_ELEMENT;
            header_limit_reg <= dtve_pkg::RST_HEADER_LIMIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dtve_pkg::CFG_TAG_GROUP:    tag_group_reg    <= cfg_data;
                dtve_pkg::CFG_TAG_ELEMENT:  tag_element_reg  <= cfg_data;
                dtve_pkg::CFG_HEADER_LIMIT: header_limit_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= dtve_pkg::PH_SEARCH;
            window_reg    <= '0;
            pos_reg       <= '0;
            hdr_cnt_reg   <= '0;
            len_bytes_reg <= '0;
            vlen_reg      <= '0;
            vcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg     <= phase_next;
                window_reg    <= window_next;
                pos_reg       <= pos_next;
                hdr_cnt_reg   <= hdr_cnt_next;
                len_bytes_reg <= len_bytes_next;
                vlen_reg      <= vlen_next;
                vcnt_reg      <= vcnt_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    // value phase always has a nonzero length and room for another byte
    a_value_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == dtve_pkg::PH_VALUE) |-> (vlen_reg != '0) && (vcnt_reg < vlen_reg))
        else $error("value counter out of range");

    a_eos_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_data.end_of_stream)
        |=> (phase_reg == dtve_pkg::PH_SEARCH) && (pos_reg == '0))
        else $error("scan state not cleared after end of stream");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_data_reg.status != dtve_pkg::ST_VALUE)
        |-> out_data_reg.last && (out_data_reg.value_byte == 8'd0))
        else $error("status item without last or with data");

    a_hdr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == dtve_pkg::PH_LENGTH) |-> (hdr_cnt_reg < dtve_pkg::HDR_CNT_W'(4)))
        else $error("length byte counter overran");

endmodule
